// ===== sv/gffpp_pkg.sv =====
// ----------------------------------------------------------------------------
// gffpp_pkg
// Shared types and constants of the fix filter and position payload packer.
// ----------------------------------------------------------------------------
package gffpp_pkg;

  localparam int PAYLOAD_BYTES = 10;
  localparam logic [3:0] LAST_IDX = 4'(PAYLOAD_BYTES - 1);

  typedef enum logic [1:0] {
    OC_BYTE = 2'd0,
    OC_WEAK = 2'd1,
    OC_SKIP = 2'd2
  } outcome_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND  = 3'd0,
    REG_MAX_SKIPS = 3'd1,
    REG_HDOP_LIM  = 3'd2,
    REG_MIN_FIX   = 3'd3
  } cfg_reg_t;

  localparam logic [16:0] DEADBAND_RST  = 17'd1000;
  localparam logic [3:0]  MAX_SKIPS_RST = 4'd10;
  localparam logic [15:0] HDOP_LIM_RST  = 16'd200;
  localparam logic [2:0]  MIN_FIX_RST   = 3'd3;
  localparam logic [3:0]  SKIP_SAT      = 4'd15;

  localparam logic signed [30:0] LAT_SPAN = 31'sd900000000;
  localparam logic signed [31:0] LON_SPAN = 32'sd1800000000;

  // code = floor(x * 372827 / 80000000), x = offset coordinate (latitude doubled)
  localparam logic [31:0] ENC_DIV    = 32'd80000000;
  localparam logic [18:0] ENC_MUL    = 19'd372827;
  // floor(n / 78125) for n < 2**22: (n * ENC_QRECIP) >> 39
  localparam logic [22:0] ENC_QRECIP = 23'd7036875;
  // estimate of floor(w / 80000000): ((w >> 17) * ENC_RRECIP) >> 40, low by at most one
  localparam logic [30:0] ENC_RRECIP = 31'd1801439850;

  // floor(n / 1000) for n < 2**26: (n * ALT_RECIP) >> 36
  localparam logic [26:0] ALT_RECIP  = 27'd68719477;
  // floor(n / 10) for n < 2**16: (n * HDOP_RECIP) >> 19
  localparam logic [15:0] HDOP_RECIP = 16'd52429;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] alt_m;
    logic [7:0]  hdop_q;
    logic [7:0]  batt;
  } side_t;

endpackage

// ===== sv/gffpp_coord_enc.sv =====
// ----------------------------------------------------------------------------
// gffpp_coord_enc
// Six-stage pipeline mapping an offset coordinate to its 24-bit payload code.
// ----------------------------------------------------------------------------
module gffpp_coord_enc (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] x,
  output logic [23:0] code
);

  logic [31:0] x1;
  logic [44:0] qprod;
  logic [5:0]  qx2;
  logic [31:0] x2;
  logic [31:0] qmul;
  logic [31:0] rdiff;
  logic [26:0] rx3;
  logic [5:0]  qx3;
  logic [44:0] w4;
  logic [23:0] base4;
  logic [58:0] p5;
  logic [44:0] w5;
  logic [23:0] base5;
  logic [18:0] qa;
  logic [45:0] m6;
  logic [44:0] w6;
  logic [23:0] bq6;

  assign qprod = 45'(x1[31:10]) * 45'(gffpp_pkg::ENC_QRECIP);
  assign qmul  = 32'(qx2) * gffpp_pkg::ENC_DIV;
  assign rdiff = x2 - qmul;
  assign qa    = p5[58:40];
  assign code  = bq6 + 24'(46'(w6) >= m6);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= x;
      qx2   <= qprod[44:39];
      x2    <= x1;
      rx3   <= rdiff[26:0];
      qx3   <= qx2;
      w4    <= 45'(rx3) * 45'(gffpp_pkg::ENC_MUL);
      base4 <= 24'(qx3) * 24'(gffpp_pkg::ENC_MUL);
      p5    <= 59'(w4[44:17]) * 59'(gffpp_pkg::ENC_RRECIP);
      w5    <= w4;
      base5 <= base4;
      m6    <= (46'(qa) + 46'd1) * 46'(gffpp_pkg::ENC_DIV);
      bq6   <= base5 + 24'(qa);
      w6    <= w5;
    end
  end

endmodule

// ===== sv/gps_fix_filter_payload_packer.sv =====
// ----------------------------------------------------------------------------
// gps_fix_filter_payload_packer
// Filters GNSS fixes (weak fix, unchanged position) and packs sent fixes into
// a ten-byte position payload, one byte per result.
// ----------------------------------------------------------------------------
// An accepted fix passes the input register, the encoder and side-path stages
// and the output register. Throughput: one fix per cycle enters while the
// output register is free; a sent fix holds it until its ten bytes are taken,
// a reject or skip until its single result is. All stages advance together.
// Reset: clears valids, stored position and skip counter; loads register
// defaults (deadband 1000, max_skips 10, hdop_limit 200, min_fix_type 3).
module gps_fix_filter_payload_packer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gffpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gffpp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           fix_kind,
  input  logic signed [30:0]                   lat_e7,
  input  logic signed [31:0]                   lon_e7,
  input  logic signed [25:0]                   alt_mm,
  input  logic [15:0]                          hdop_centi,
  input  logic [9:0]                           battery_cv,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           outcome,
  output logic [3:0]                           byte_index,
  output logic [7:0]                           payload_byte,
  output logic                                 last
);

  logic [16:0] deadband;
  logic [3:0]  max_skips;
  logic [15:0] hdop_limit;
  logic [2:0]  min_fix_type;

  logic signed [30:0] sent_latitude;
  logic signed [31:0] sent_longitude;
  logic [3:0]         skip_count;

  logic               s0_valid;
  logic [2:0]         s0_fix;
  logic signed [30:0] s0_lat;
  logic signed [31:0] s0_lon;
  logic signed [25:0] s0_alt;
  logic [15:0]        s0_hdop;
  logic [9:0]         s0_batt;

  logic               advance;
  logic               poor_fix;
  logic               unchanged;
  logic [3:0]         skip_inc;
  gffpp_pkg::outcome_t oc0;
  logic signed [32:0] dlat;
  logic signed [32:0] dlon;
  logic [32:0]        alat;
  logic [32:0]        alon;
  logic signed [30:0] lat_c;
  logic signed [31:0] lon_c;
  logic signed [32:0] lat_off;
  logic signed [32:0] lon_off;
  logic [31:0]        xlat;
  logic [31:0]        xlon;
  logic [25:0]        alt_abs;

  logic [6:1]          v;
  gffpp_pkg::outcome_t oc1;
  logic [25:0]         alt_abs1;
  logic                alt_neg1;
  logic [15:0]         hdop1;
  logic [7:0]          batt1;
  gffpp_pkg::outcome_t oc2;
  logic [52:0]         altp2;
  logic                alt_neg2;
  logic [31:0]         hdopp2;
  logic [7:0]          batt2;
  logic [15:0]         alt_q;
  gffpp_pkg::side_t    side3;
  gffpp_pkg::side_t    side_q [3:6];

  logic [23:0] lat_code;
  logic [23:0] lon_code;

  logic                ov;
  logic [3:0]          ocnt;
  gffpp_pkg::outcome_t o_outcome;
  logic [23:0]         o_lat;
  logic [23:0]         o_lon;
  logic [15:0]         o_alt;
  logic [7:0]          o_hdop;
  logic [7:0]          o_batt;
  logic                out_last;
  logic [7:0]          byte_sel;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= gffpp_pkg::DEADBAND_RST;
      max_skips    <= gffpp_pkg::MAX_SKIPS_RST;
      hdop_limit   <= gffpp_pkg::HDOP_LIM_RST;
      min_fix_type <= gffpp_pkg::MIN_FIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (gffpp_pkg::cfg_reg_t'(cfg_index))
        gffpp_pkg::REG_DEADBAND:  deadband     <= cfg_data[16:0];
        gffpp_pkg::REG_MAX_SKIPS: max_skips    <= cfg_data[3:0];
        gffpp_pkg::REG_HDOP_LIM:  hdop_limit   <= cfg_data[15:0];
        gffpp_pkg::REG_MIN_FIX:   min_fix_type <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_last = (o_outcome != gffpp_pkg::OC_BYTE) || (ocnt == gffpp_pkg::LAST_IDX);
  assign advance  = !ov || (!out_stall && out_last);
  assign in_stall = !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_fix  <= fix_kind;
      s0_lat  <= lat_e7;
      s0_lon  <= lon_e7;
      s0_alt  <= alt_mm;
      s0_hdop <= hdop_centi;
      s0_batt <= battery_cv;
    end
  end

  // filter decision
  assign poor_fix = (s0_fix < min_fix_type) && (s0_hdop > hdop_limit);
  assign dlat = 33'(s0_lat) - 33'(sent_latitude);
  assign dlon = 33'(s0_lon) - 33'(sent_longitude);
  assign alat = dlat[32] ? 33'(-dlat) : 33'(dlat);
  assign alon = dlon[32] ? 33'(-dlon) : 33'(dlon);
  assign unchanged = (alat < 33'(deadband)) && (alon < 33'(deadband));
  assign skip_inc = (skip_count < gffpp_pkg::SKIP_SAT) ? skip_count + 4'd1 : skip_count;

  always_comb begin
    if (poor_fix) begin
      oc0 = gffpp_pkg::OC_WEAK;
    end else if (unchanged && (skip_inc < max_skips)) begin
      oc0 = gffpp_pkg::OC_SKIP;
    end else begin
      oc0 = gffpp_pkg::OC_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_latitude  <= '0;
      sent_longitude <= '0;
      skip_count     <= '0;
    end else if (advance && s0_valid) begin
      case (oc0)
        gffpp_pkg::OC_BYTE: begin
          sent_latitude  <= s0_lat;
          sent_longitude <= s0_lon;
          skip_count     <= '0;
        end
        gffpp_pkg::OC_SKIP: skip_count <= skip_inc;
        default: ;
      endcase
    end
  end

  // coordinate offsets; latitude doubled to share the longitude divisor
  assign lat_c = (s0_lat > gffpp_pkg::LAT_SPAN) ? gffpp_pkg::LAT_SPAN :
                 (s0_lat < -gffpp_pkg::LAT_SPAN) ? -gffpp_pkg::LAT_SPAN : s0_lat;
  assign lon_c = (s0_lon > gffpp_pkg::LON_SPAN) ? gffpp_pkg::LON_SPAN :
                 (s0_lon < -gffpp_pkg::LON_SPAN) ? -gffpp_pkg::LON_SPAN : s0_lon;
  assign lat_off = 33'(lat_c) + 33'(gffpp_pkg::LAT_SPAN);
  assign lon_off = 33'(lon_c) + 33'(gffpp_pkg::LON_SPAN);
  assign xlat = {lat_off[30:0], 1'b0};
  assign xlon = lon_off[31:0];

  gffpp_coord_enc u_lat_enc (
    .clk  (clk),
    .adv  (advance),
    .x    (xlat),
    .code (lat_code)
  );

  gffpp_coord_enc u_lon_enc (
    .clk  (clk),
    .adv  (advance),
    .x    (xlon),
    .code (lon_code)
  );

  // altitude, HDOP and battery side path
  assign alt_abs = s0_alt[25] ? 26'(-s0_alt) : 26'(s0_alt);
  assign alt_q   = altp2[51:36];

  always_comb begin
    side3.outcome = oc2;
    side3.alt_m   = alt_neg2 ? 16'(-alt_q) : alt_q;
    side3.hdop_q  = hdopp2[26:19];
    side3.batt    = batt2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[5:1], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oc1       <= oc0;
      alt_abs1  <= alt_abs;
      alt_neg1  <= s0_alt[25];
      hdop1     <= s0_hdop;
      batt1     <= s0_batt[7:0];
      oc2       <= oc1;
      altp2     <= 53'(alt_abs1) * 53'(gffpp_pkg::ALT_RECIP);
      alt_neg2  <= alt_neg1;
      hdopp2    <= 32'(hdop1) * 32'(gffpp_pkg::HDOP_RECIP);
      batt2     <= batt1;
      side_q[3] <= side3;
      side_q[4] <= side_q[3];
      side_q[5] <= side_q[4];
      side_q[6] <= side_q[5];
    end
  end

  // output register and byte sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      ocnt <= '0;
    end else if (advance) begin
      ov   <= v[6];
      ocnt <= '0;
    end else if (!out_stall) begin
      ocnt <= ocnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_outcome <= gffpp_pkg::OC_BYTE;
    end else if (advance) begin
      o_outcome <= side_q[6].outcome;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_lat  <= lat_code;
      o_lon  <= lon_code;
      o_alt  <= side_q[6].alt_m;
      o_hdop <= side_q[6].hdop_q;
      o_batt <= side_q[6].batt;
    end
  end

  always_comb begin
    case (ocnt)
      4'd0:    byte_sel = o_lat[23:16];
      4'd1:    byte_sel = o_lat[15:8];
      4'd2:    byte_sel = o_lat[7:0];
      4'd3:    byte_sel = o_lon[23:16];
      4'd4:    byte_sel = o_lon[15:8];
      4'd5:    byte_sel = o_lon[7:0];
      4'd6:    byte_sel = o_alt[15:8];
      4'd7:    byte_sel = o_alt[7:0];
      4'd8:    byte_sel = o_hdop;
      4'd9:    byte_sel = o_batt;
      default: byte_sel = '0;
    endcase
  end

  assign out_valid    = ov;
  assign outcome      = o_outcome;
  assign byte_index   = ocnt;
  assign payload_byte = (o_outcome == gffpp_pkg::OC_BYTE) ? byte_sel : 8'd0;
  assign last         = out_last;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ov |-> ocnt <= gffpp_pkg::LAST_IDX)
    else $error("byte counter past last payload byte");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (ov && o_outcome != gffpp_pkg::OC_BYTE) |-> ocnt == 4'd0)
    else $error("rejected or skipped fix gave more than one result");

  a_send_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s0_valid && oc0 == gffpp_pkg::OC_BYTE) |=> skip_count == 4'd0)
    else $error("skip counter not cleared on send");

  a_skip_below_max: assert property (@(posedge clk) disable iff (rst)
    (advance && s0_valid && oc0 == gffpp_pkg::OC_SKIP && !cfg_valid)
      |=> skip_count < max_skips)
    else $error("fix skipped with counter at maximum");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s0_valid)
    else $error("accepted request lost at input register");

endmodule

// ===== tb/gps_fix_filter_payload_packer_test.sv =====
// ----------------------------------------------------------------------------
// gps_fix_filter_payload_packer_test
// Drives GNSS fixes through the fix filter and payload packer under several
// register settings and random stalls on both sides. Every request is
// predicted as a weak-fix reject, an unchanged-position skip or a ten-byte
// position payload, and each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module gps_fix_filter_payload_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gffpp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_FIXES = 48;
  localparam int MAX_WAIT = 17;
  localparam int HOLD_OFF = 12;
  localparam int SHOWN_ERRORS = 10;
  localparam longint CODE_FULL = 16777215;
  localparam longint LAT_LIM = 900000000;
  localparam longint LON_LIM = 1800000000;

  typedef struct {
    logic [2:0]         kind;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [25:0] alt;
    logic [15:0]        hdop;
    logic [9:0]         batt;
  } fix_t;

  typedef struct {
    outcome_t   oc;
    logic [3:0] idx;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] fix_kind = '0;
  logic signed [30:0] lat_e7 = '0;
  logic signed [31:0] lon_e7 = '0;
  logic signed [25:0] alt_mm = '0;
  logic [15:0] hdop_centi = '0;
  logic [9:0] battery_cv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] outcome;
  logic [3:0] byte_index;
  logic [7:0] payload_byte;
  logic last;

  gps_fix_filter_payload_packer dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of registers and filter state
  logic [16:0] deadband_r = DEADBAND_RST;
  logic [3:0] max_skips_r = MAX_SKIPS_RST;
  logic [15:0] hdop_lim_r = HDOP_LIM_RST;
  logic [2:0] min_fix_r = MIN_FIX_RST;
  logic signed [30:0] sent_lat = '0;
  logic signed [31:0] sent_lon = '0;
  logic [3:0] skips = '0;

  fix_t pending_fixes[$];
  result_t bytes_due[$];
  fix_t next_fix;
  int fixes_queued = 0;
  int fixes_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int fix_gap = 0;
  int byte_hold = 0;
  logic fix_taken = 1'b0;
  logic result_taken = 1'b0;
  logic [16:0] db_now = DEADBAND_RST;

  function automatic longint clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint distance(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic pack_fix(input fix_t f);
    longint lat, lon, lat_code, lon_code, alt_m;
    logic [15:0] hdop_q;
    logic [9:0] batt_q;
    logic [7:0] pay[PAYLOAD_BYTES];
    lat = f.lat;
    lon = f.lon;
    if (f.kind < min_fix_r && f.hdop > hdop_lim_r) begin
      bytes_due.push_back('{OC_WEAK, 4'd0, 8'd0, 1'b1});
      return;
    end
    if (distance(lat, sent_lat) < longint'(deadband_r) &&
        distance(lon, sent_lon) < longint'(deadband_r)) begin
      if (skips < SKIP_SAT) skips++;
      if (skips < max_skips_r) begin
        bytes_due.push_back('{OC_SKIP, 4'd0, 8'd0, 1'b1});
        return;
      end
    end
    skips = '0;
    sent_lat = f.lat;
    sent_lon = f.lon;
    lat_code = (clamp(lat, LAT_LIM) + LAT_LIM) * CODE_FULL / (2 * LAT_LIM);
    lon_code = (clamp(lon, LON_LIM) + LON_LIM) * CODE_FULL / (2 * LON_LIM);
    alt_m = longint'(f.alt) / 1000;
    hdop_q = f.hdop / 16'd10;
    batt_q = f.batt - 10'd256;
    pay[0] = 8'(lat_code >> 16);
    pay[1] = 8'(lat_code >> 8);
    pay[2] = 8'(lat_code);
    pay[3] = 8'(lon_code >> 16);
    pay[4] = 8'(lon_code >> 8);
    pay[5] = 8'(lon_code);
    pay[6] = 8'(alt_m >> 8);
    pay[7] = 8'(alt_m);
    pay[8] = hdop_q[7:0];
    pay[9] = batt_q[7:0];
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      bytes_due.push_back('{OC_BYTE, 4'(i), pay[i], 1'(i == PAYLOAD_BYTES - 1)});
    end
  endtask

  task automatic check_result();
    result_t want;
    if (bytes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("unexpected result: outcome %0d index %0d byte %02h last %0b",
                 outcome, byte_index, payload_byte, last);
      return;
    end
    want = bytes_due.pop_front();
    if (outcome !== want.oc || byte_index !== want.idx ||
        payload_byte !== want.data || last !== want.last) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("result %0d: expected outcome %0d index %0d byte %02h last %0b, got %0d %0d %02h %0b",
                 results_seen, want.oc, want.idx, want.data, want.last,
                 outcome, byte_index, payload_byte, last);
    end
  endtask

  // driver: hold the request while stalled, advance after acceptance
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      fix_gap = 0;
    end else if (!in_valid || fix_taken) begin
      if (fix_taken) fix_gap = draw_wait((fixes_taken / 24) % 3 == 1);
      if (fix_gap > 0) begin
        fix_gap--;
        in_valid <= 1'b0;
      end else if (pending_fixes.size() != 0) begin
        next_fix = pending_fixes.pop_front();
        fix_kind <= next_fix.kind;
        lat_e7 <= next_fix.lat;
        lon_e7 <= next_fix.lon;
        alt_mm <= next_fix.alt;
        hdop_centi <= next_fix.hdop;
        battery_cv <= next_fix.batt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      byte_hold = 0;
    end else begin
      if (result_taken) byte_hold = draw_wait((results_seen / 40) % 3 == 1);
      if (byte_hold > 0) begin
        byte_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    fix_taken <= !rst && in_valid && !in_stall;
    result_taken <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEADBAND:  deadband_r = cfg_data;
          REG_MAX_SKIPS: max_skips_r = cfg_data[3:0];
          REG_HDOP_LIM:  hdop_lim_r = cfg_data[15:0];
          REG_MIN_FIX:   min_fix_r = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pack_fix('{fix_kind, lat_e7, lon_e7, alt_mm, hdop_centi, battery_cv});
        fixes_taken++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("gps_fix_filter_payload_packer_test: errors");
        $finish;
      end
    end
  end

  task automatic queue_fix(input logic [2:0] kind, input logic signed [30:0] lat,
                           input logic signed [31:0] lon, input logic signed [25:0] alt,
                           input logic [15:0] hdop, input logic [9:0] batt);
    pending_fixes.push_back('{kind, lat, lon, alt, hdop, batt});
    fixes_queued++;
  endtask

  task automatic drain();
    while (fixes_taken != fixes_queued || bytes_due.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [16:0] db, input logic [16:0] ms,
                          input logic [16:0] hl, input logic [16:0] mf);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_MAX_SKIPS, ms);
    write_reg(REG_HDOP_LIM, hl);
    write_reg(REG_MIN_FIX, mf);
    db_now = db;
  endtask

  // mostly tracks that wander around an anchor, some jumps, weak fixes and noise
  task automatic gen_phase(input int count);
    int span, pick, lat_base;
    longint lon_base;
    lat_base = int'($urandom_range(0, 1800000000)) - 900000000;
    lon_base = longint'($urandom_range(0, 32'd3600000000)) - LON_LIM;
    for (int n = 0; n < count; n++) begin
      span = int'(db_now) + int'(db_now) / 4 + 1;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        lat_base = int'($urandom_range(0, 1800000000)) - 900000000;
        lon_base = longint'($urandom_range(0, 32'd3600000000)) - LON_LIM;
      end
      if (pick >= 88)
        queue_fix(3'($urandom), 31'($urandom), 32'($urandom), 26'($urandom),
                  16'($urandom), 10'($urandom));
      else
        queue_fix(3'($urandom_range(0, 7)),
                  31'(lat_base + int'($urandom_range(0, 2 * span)) - span),
                  32'(lon_base + longint'($urandom_range(0, 2 * span)) - span),
                  26'(int'($urandom_range(0, 30500000)) - 500000),
                  (pick >= 75) ? 16'($urandom) : 16'($urandom_range(0, 250)),
                  10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_fix(3'd2, 31'sd0, 32'sd0, 26'sd0, 16'd201, 10'd300);
    queue_fix(3'd2, 31'sd999, -32'sd999, 26'sd0, 16'd200, 10'd300);
    queue_fix(3'd7, 31'sd1000, 32'sd0, 26'sd0, 16'd65535, 10'd0);
    queue_fix(3'd0, 31'sd900000000, 32'sd1800000000, 26'sd30000000, 16'd0, 10'd600);
    queue_fix(3'd5, -31'sd900000000, -32'sd1800000000, -26'sd500000, 16'd65535, 10'd1023);
    queue_fix(3'd4, 31'h3FFFFFFF, 32'h7FFFFFFF, 26'h1FFFFFF, 16'd150, 10'd255);
    queue_fix(3'd3, 31'h40000000, 32'h80000000, 26'h2000000, 16'd9, 10'd256);
    queue_fix(3'd3, 31'sd123456789, -32'sd98765432, -26'sd999, 16'd120, 10'd257);
    for (int k = 1; k <= 10; k++)
      queue_fix(3'd3, 31'(123456789 + 50 * k), 32'(-98765432 - 30 * k),
                26'(1000 * k), 16'd100, 10'd400);
    queue_fix(3'd3, -31'sd45000000, 32'sd100000000, -26'sd1000, 16'd500, 10'd380);
    queue_fix(3'd1, -31'sd45000000, 32'sd100000000, 26'sd0, 16'd65535, 10'd380);
    drain();

    set_regs(17'd0, 17'd1, 17'd0, 17'd0);
    gen_phase(PHASE_FIXES);
    drain();
    set_regs(17'd100000, 17'd15, 17'd65535, 17'd5);
    gen_phase(PHASE_FIXES);
    drain();
    set_regs(17'h1FFFF, 17'd0, 17'd200, 17'd7);
    gen_phase(PHASE_FIXES);
    drain();
    set_regs(17'($urandom_range(0, 5000)), 17'($urandom_range(0, 15)),
             17'($urandom_range(0, 400)), 17'($urandom_range(0, 7)));
    gen_phase(PHASE_FIXES);
    drain();
    set_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
    gen_phase(PHASE_FIXES);
    drain();
    set_regs(DEADBAND_RST, 17'(MAX_SKIPS_RST), 17'(HDOP_LIM_RST), 17'(MIN_FIX_RST));
    gen_phase(PHASE_FIXES);
    drain();

    if (mismatches == 0)
      $display("gps_fix_filter_payload_packer_test: clean");
    else
      $display("gps_fix_filter_payload_packer_test: errors");
    $finish;
  end

endmodule
